[sv/rx_ring_buffer_with_skip_core_assert.svh]
// Assertion macros for the receive ring buffer checker.
// Both macros expect a signal named clk in the scope where they are used; RRBS_ASSERT also expects rst_n.
`ifndef RX_RING_BUFFER_WITH_SKIP_CORE_ASSERT_SVH
`define RX_RING_BUFFER_WITH_SKIP_CORE_ASSERT_SVH

// This check is switched off while reset is asserted.
`define RRBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// This check also holds during reset.
`define RRBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rrbs_pkg.sv]
// ----------------------------------------------------------------------------
// rrbs_pkg
// Shared types and constants for the receive ring buffer with delimiter skip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrbs_pkg;

    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int OCC_W     = 6;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SKIP   = 2'd2,
        OP_STATUS = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SKIP_CMP,
        ST_SKIP_WAIT,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic skip_step;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic count_zero;
        logic walk_end;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[sv/rx_ring_buffer_with_skip_core.sv]
// Write, read and status words pass from the accept through the execute state
// to the output state, and m_tvalid rises once the output register is loaded.
// A skip pops one stored byte per compare state (none on an empty buffer), with
// a wait state between compares, as the byte store has a registered read port.
// Reset (rst_n low, asynchronous) empties the buffer, clears the pending skip
// and the output valid; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
// rx_ring_buffer_with_skip_core
// Receive byte ring buffer holding DEPTH-1 bytes, with a skip-to-delimiter
// operation that can stay pending across later writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rx_ring_buffer_with_skip_core #(
    parameter int DEPTH = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input words.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rrbs_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] byte_value
    input  wire logic [rrbs_pkg::OP_W-1:0]      s_tuser,  // [1:0] operation
    // Result words.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] read_byte, [13:8] occupancy, [14] was_empty, [15] write_dropped,
    // [16] skip_pending_out, [23:17] zero
    output logic      [rrbs_pkg::M_TDATA_W-1:0] m_tdata
);

    // The controller only sequences; the datapath holds all the state of the
    // buffer. They talk through one command and one status struct.
    rrbs_pkg::cmd_t    cmd;
    rrbs_pkg::status_t status;

    rrbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath keeps the pointers, the skip flag and delimiter, and the
    // byte store. A skip walk compares one stored byte against the delimiter
    // each compare step and pops it; it ends on a match or when the buffer
    // runs empty, in which case the skip stays pending for later writes.
    rrbs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

[sv/rrbs_ram.sv]
// ----------------------------------------------------------------------------
// rrbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/rrbs_ctrl.sv]
// ----------------------------------------------------------------------------
// rrbs_ctrl
// Sequencer: accepts one word at a time, runs it and the skip walk, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrbs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire rrbs_pkg::status_t status,
    output rrbs_pkg::cmd_t        cmd
);

    rrbs_pkg::state_t state_reg;
    rrbs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrbs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrbs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = rrbs_pkg::ST_EXEC;
                end
            end
            rrbs_pkg::ST_EXEC:
            begin
                if (status.op == rrbs_pkg::OP_SKIP && !status.count_zero)
                begin
                    state_next = rrbs_pkg::ST_SKIP_CMP;
                end
                else
                begin
                    state_next = rrbs_pkg::ST_OUT;
                end
            end
            rrbs_pkg::ST_SKIP_CMP:
            begin
                state_next = status.walk_end ? rrbs_pkg::ST_OUT : rrbs_pkg::ST_SKIP_WAIT;
            end
            rrbs_pkg::ST_SKIP_WAIT:
            begin
                state_next = rrbs_pkg::ST_SKIP_CMP;
            end
            rrbs_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = s_tvalid ? rrbs_pkg::ST_EXEC : rrbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = (state_reg == rrbs_pkg::ST_IDLE) ||
                        (state_reg == rrbs_pkg::ST_OUT && status.out_free);
        cmd.accept    = s_tvalid && s_tready;
        cmd.exec      = (state_reg == rrbs_pkg::ST_EXEC);
        cmd.skip_step = (state_reg == rrbs_pkg::ST_SKIP_CMP);
        cmd.load_out  = (state_reg == rrbs_pkg::ST_OUT) && status.out_free;
    end

endmodule

`default_nettype wire

[sv/rrbs_dp.sv]
// ----------------------------------------------------------------------------
// rrbs_dp
// Datapath: pointers, skip state, byte store, result and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrbs_dp #(
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [rrbs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [rrbs_pkg::OP_W-1:0]        s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [rrbs_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire rrbs_pkg::cmd_t                   cmd,
    output rrbs_pkg::status_t                     status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = (PW > rrbs_pkg::OCC_W) ? PW : rrbs_pkg::OCC_W;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    rrbs_pkg::op_t                   op_reg;
    logic [rrbs_pkg::BYTE_W-1:0]     val_reg;
    logic [PW-1:0]                   count_reg;
    logic [PW-1:0]                   rp_reg;
    logic [PW-1:0]                   wp_reg;
    logic                            armed_reg;
    logic [rrbs_pkg::BYTE_W-1:0]     delim_reg;
    logic [rrbs_pkg::BYTE_W-1:0]     rbyte_reg;
    logic                            empty_reg;
    logic                            dropped_reg;
    logic                            out_valid_reg;
    logic [rrbs_pkg::M_TDATA_W-1:0]  out_data_reg;

    logic [PW:0]                     diff;
    logic [PW:0]                     diff_wrap;
    logic [PW-1:0]                   count_now;
    logic [PW-1:0]                   rp_inc;
    logic [PW-1:0]                   wp_inc;
    logic [rrbs_pkg::BYTE_W-1:0]     rdata;
    logic                            mem_we;
    logic                            full;
    logic                            match;
    logic [CW-1:0]                   count_ext;

    // Occupancy from the pointers; the store has DEPTH slots, one kept free.
    assign diff      = {1'b0, wp_reg} - {1'b0, rp_reg};
    assign diff_wrap = diff + (PW + 1)'(DEPTH);
    assign count_now = (wp_reg >= rp_reg) ? diff[PW-1:0] : diff_wrap[PW-1:0];

    assign rp_inc = (rp_reg == LAST) ? '0 : rp_reg + 1'b1;
    assign wp_inc = (wp_reg == LAST) ? '0 : wp_reg + 1'b1;
    assign full   = (wp_inc == rp_reg);
    assign match  = (rdata == val_reg);
    assign mem_we = cmd.exec && op_reg == rrbs_pkg::OP_WRITE && !armed_reg && !full;

    rrbs_ram #(
        .WIDTH (rrbs_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wp_reg),
        .wdata (val_reg),
        .raddr (rp_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            armed_reg     <= 1'b0;
            delim_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                case (op_reg)
                    rrbs_pkg::OP_WRITE:
                    begin
                        if (armed_reg)
                        begin
                            if (val_reg == delim_reg)
                            begin
                                armed_reg <= 1'b0;
                            end
                        end
                        else if (!full)
                        begin
                            wp_reg <= wp_inc;
                        end
                    end
                    rrbs_pkg::OP_READ:
                    begin
                        if (count_reg != '0)
                        begin
                            rp_reg <= rp_inc;
                        end
                    end
                    rrbs_pkg::OP_SKIP:
                    begin
                        delim_reg <= val_reg;
                        if (count_reg == '0)
                        begin
                            armed_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.skip_step)
            begin
                rp_reg <= rp_inc;
                if (match)
                begin
                    armed_reg <= 1'b0;
                end
                else if (rp_inc == wp_reg)
                begin
                    armed_reg <= 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign count_ext = CW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= rrbs_pkg::op_t'(s_tuser);
            val_reg   <= s_tdata[rrbs_pkg::BYTE_W-1:0];
            count_reg <= count_now;
        end
        if (cmd.exec)
        begin
            rbyte_reg   <= '0;
            empty_reg   <= 1'b0;
            dropped_reg <= 1'b0;
            case (op_reg)
                rrbs_pkg::OP_WRITE:
                begin
                    dropped_reg <= armed_reg || full;
                end
                rrbs_pkg::OP_READ:
                begin
                    if (count_reg == '0)
                    begin
                        empty_reg <= 1'b1;
                    end
                    else
                    begin
                        rbyte_reg <= rdata;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {7'd0, armed_reg, dropped_reg, empty_reg,
                             count_ext[rrbs_pkg::OCC_W-1:0], rbyte_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        status.op         = op_reg;
        status.count_zero = (count_reg == '0);
        status.walk_end   = match || (rp_inc == wp_reg);
        status.out_free   = !out_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

[sv/rrbs_checker.sv]
// ----------------------------------------------------------------------------
// rrbs_checker
// Port-level checks for the receive ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rx_ring_buffer_with_skip_core_assert.svh"

module rrbs_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [rrbs_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result word holds.
    `RRBS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // Only one word is in execution: ready drops after every accept.
    `RRBS_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "input accepted twice in a row")

    // An empty read carries no byte and no occupancy.
    `RRBS_ASSERT(a_empty_clean, m_tvalid && m_tdata[14] |-> m_tdata[13:0] == 14'd0, "empty read with nonzero byte or occupancy")

    // A word cannot be both an empty read and a dropped write, and padding is zero.
    `RRBS_ASSERT(a_flags_excl, m_tvalid |-> !(m_tdata[14] && m_tdata[15]) && m_tdata[23:17] == 7'd0, "inconsistent result flags")

    // No result is shown while reset is asserted.
    `RRBS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind rx_ring_buffer_with_skip_core rrbs_checker u_rrbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[verif/tb_rx_ring_buffer_with_skip_core.sv]
// ----------------------------------------------------------------------------
// tb_rx_ring_buffer_with_skip_core
// Self-checking bench for the receive ring buffer with delimiter skip. A
// clocked driver feeds operation words from a queue that an initial block
// fills with a short directed list and then with random sequences of bursts
// and skips. A monitor predicts each result as its word is accepted and
// compares every returned word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rx_ring_buffer_with_skip_core;

    localparam int DEPTH        = 64;
    localparam int RANDOM_WORDS = 1630;
    // The longest honest quiet spell is a receiver hold-off of HOLD_CYCLES
    // plus a skip over a full buffer and a long gap on
    // either side; the limit is several times that.
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    // A skip over a full buffer is the slowest word the block handles.
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        rrbs_pkg::op_t op;
        logic [7:0]    value;
    } buf_word_t;

    typedef struct {
        logic [7:0] rd_byte;
        logic [5:0] occ;
        logic       empty;
        logic       dropped;
        logic       skip_pend;
    } buf_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rrbs_pkg::S_TDATA_W-1:0] s_tdata;   // [7:0] byte_value
    logic [rrbs_pkg::OP_W-1:0]      s_tuser;   // [1:0] operation
    logic                           m_tvalid;
    logic                           m_tready;
    // [7:0] read_byte, [13:8] occupancy, [14] was_empty, [15] write_dropped,
    // [16] skip_pending_out, [23:17] zero
    logic [rrbs_pkg::M_TDATA_W-1:0] m_tdata;

    rx_ring_buffer_with_skip_core #(
        .DEPTH (DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Words waiting to be sent and results waiting to come back.
    buf_word_t   pending_words[$];
    buf_result_t expected_results[$];

    // Shadow copy of the buffer, advanced once per accepted word.
    logic [7:0] shadow_store[DEPTH];
    int         shadow_rd;
    int         shadow_wr;
    bit         shadow_armed;
    logic [7:0] shadow_delim;

    buf_word_t  cur_word;
    bit         word_taken;
    int         send_gap;
    int         send_stretch;
    bit         send_steady;
    int         recv_stall;
    int         recv_stretch;
    bit         recv_steady;
    int         hold_left;
    int         holds_done;
    int         idle_cycles;
    int         words_in;
    int         results_checked;
    int         errors;
    int         n_write;
    int         n_read;
    int         n_skip;
    int         n_status;
    int         n_full_drop;
    int         n_skip_drop;
    int         n_empty_read;
    int         n_skip_left_armed;

    always #5 clk = ~clk;

    // Gap length for either side: mostly none or short, now and then long.
    // In a steady stretch there is no idling at all.
    function automatic int pick_delay(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Bytes lean toward the extremes now and then.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else
            return 8'($urandom);
    endfunction

    task automatic add_word(rrbs_pkg::op_t op, logic [7:0] value);
        buf_word_t w;
        w.op    = op;
        w.value = value;
        pending_words.push_back(w);
    endtask

    // Works out the result of one word and advances the shadow buffer.
    task automatic predict_buffer(buf_word_t w, output buf_result_t res);
        int held;
        int nxt;
        bit found;
        logic [7:0] b;
        held          = (DEPTH + shadow_wr - shadow_rd) % DEPTH;
        res.rd_byte   = 8'h00;
        res.occ       = 6'(held);
        res.empty     = 1'b0;
        res.dropped   = 1'b0;
        case (w.op)
            rrbs_pkg::OP_WRITE:
            begin
                n_write++;
                if (shadow_armed)
                begin
                    // A pending skip swallows the byte; the delimiter ends it.
                    res.dropped = 1'b1;
                    n_skip_drop++;
                    if (w.value == shadow_delim)
                        shadow_armed = 1'b0;
                end
                else
                begin
                    nxt = (shadow_wr + 1) % DEPTH;
                    if (nxt == shadow_rd)
                    begin
                        res.dropped = 1'b1;
                        n_full_drop++;
                    end
                    else
                    begin
                        shadow_store[shadow_wr] = w.value;
                        shadow_wr = nxt;
                    end
                end
            end
            rrbs_pkg::OP_READ:
            begin
                n_read++;
                if (held == 0)
                begin
                    res.empty = 1'b1;
                    res.occ   = 6'd0;
                    n_empty_read++;
                end
                else
                begin
                    res.rd_byte = shadow_store[shadow_rd];
                    shadow_rd   = (shadow_rd + 1) % DEPTH;
                end
            end
            rrbs_pkg::OP_SKIP:
            begin
                n_skip++;
                found = 1'b0;
                for (int i = 0; i < held && !found; i++)
                begin
                    b = shadow_store[shadow_rd];
                    shadow_rd = (shadow_rd + 1) % DEPTH;
                    if (b == w.value)
                        found = 1'b1;
                end
                shadow_armed = !found;
                shadow_delim = w.value;
                if (!found)
                    n_skip_left_armed++;
            end
            default:
                n_status++;
        endcase
        res.skip_pend = shadow_armed;
    endtask

    task automatic check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val)
        begin
            errors++;
            $display("%0t: result %0d field %s expected 0x%0h, got 0x%0h",
                     $time, results_checked, name, exp_val, got_val);
        end
    endtask

    // Sender: one word on the bus at a time, changed at the falling edge.
    always @(negedge clk)
    begin : sender
        bit next_valid;
        if (rst_n)
        begin
            next_valid = s_tvalid && !word_taken;
            word_taken = 1'b0;
            if (send_stretch == 0)
            begin
                send_stretch = $urandom_range(50, 300);
                send_steady  = ($urandom_range(0, 2) == 0);
            end
            else
                send_stretch--;
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_words.size() > 0)
                begin
                    cur_word   = pending_words.pop_front();
                    next_valid = 1'b1;
                    s_tdata   <= rrbs_pkg::S_TDATA_W'(cur_word.value);
                    s_tuser   <= cur_word.op;
                    send_gap   = pick_delay(send_steady);
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: random stalls, plus long hold-offs that let the block fill
    // its output side and push back on the sender.
    always @(negedge clk)
    begin : receiver
        bit next_ready;
        if (rst_n)
        begin
            if (recv_stretch == 0)
            begin
                recv_stretch = $urandom_range(50, 300);
                recv_steady  = ($urandom_range(0, 2) == 0);
            end
            else
                recv_stretch--;
            if (hold_left == 0 && holds_done < 2 &&
                words_in >= ((holds_done == 0) ? 60 : 800))
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
                recv_stall = pick_delay(recv_steady);
            end
            m_tready <= next_ready;
        end
    end

    // Monitor: checks returned words against the oldest prediction, then
    // predicts the word accepted at this edge. A word's result cannot come
    // back on the edge that accepts it, so the order is safe.
    always @(posedge clk)
    begin : monitor
        bit          fired;
        buf_result_t want;
        buf_result_t fresh;
        if (rst_n)
        begin
            fired = 1'b0;
            if (m_tvalid && m_tready)
            begin
                fired = 1'b1;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got 0x%06h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_byte", want.rd_byte, m_tdata[7:0]);
                    check_field("occupancy", want.occ, m_tdata[13:8]);
                    check_field("was_empty", want.empty, m_tdata[14]);
                    check_field("write_dropped", want.dropped, m_tdata[15]);
                    check_field("skip_pending", want.skip_pend, m_tdata[16]);
                    check_field("padding", 0, m_tdata[23:17]);
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                fired = 1'b1;
                predict_buffer(cur_word, fresh);
                expected_results.push_back(fresh);
                word_taken = 1'b1;
                words_in++;
            end
            if (fired)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int         kind;
        int         n;
        int         at;
        logic [7:0] delim;
        logic [7:0] b;

        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        word_taken   = 1'b0;
        send_gap     = 0;
        send_stretch = 0;
        recv_stall   = 0;
        recv_stretch = 0;
        hold_left    = 0;
        holds_done   = 0;
        idle_cycles  = 0;
        words_in     = 0;
        shadow_rd    = 0;
        shadow_wr    = 0;
        shadow_armed = 1'b0;
        shadow_delim = 8'h00;
        foreach (shadow_store[i])
            shadow_store[i] = 8'h00;

        // Directed part: empty read, extremes, a skip that finds its
        // delimiter, a skip that stays pending, writes swallowed while
        // pending, a new skip replacing a pending one, and the delimiter
        // ending a pending skip.
        add_word(rrbs_pkg::OP_READ, 8'hFF);
        add_word(rrbs_pkg::OP_STATUS, 8'h00);
        add_word(rrbs_pkg::OP_WRITE, 8'h00);
        add_word(rrbs_pkg::OP_WRITE, 8'hFF);
        add_word(rrbs_pkg::OP_WRITE, 8'hA5);
        add_word(rrbs_pkg::OP_WRITE, 8'h5A);
        add_word(rrbs_pkg::OP_WRITE, 8'h3C);
        add_word(rrbs_pkg::OP_STATUS, 8'hFF);
        add_word(rrbs_pkg::OP_SKIP, 8'hA5);
        add_word(rrbs_pkg::OP_READ, 8'h00);
        add_word(rrbs_pkg::OP_SKIP, 8'h77);
        add_word(rrbs_pkg::OP_WRITE, 8'h11);
        add_word(rrbs_pkg::OP_READ, 8'h00);
        add_word(rrbs_pkg::OP_STATUS, 8'h00);
        add_word(rrbs_pkg::OP_SKIP, 8'h3C);
        add_word(rrbs_pkg::OP_WRITE, 8'h77);
        add_word(rrbs_pkg::OP_WRITE, 8'h3C);
        add_word(rrbs_pkg::OP_WRITE, 8'hC3);
        add_word(rrbs_pkg::OP_WRITE, 8'h00);
        add_word(rrbs_pkg::OP_SKIP, 8'h00);
        add_word(rrbs_pkg::OP_READ, 8'h00);
        add_word(rrbs_pkg::OP_WRITE, 8'hFF);
        add_word(rrbs_pkg::OP_SKIP, 8'hFF);
        add_word(rrbs_pkg::OP_STATUS, 8'h00);

        // Random part, built from sequences: write bursts long enough to
        // overrun a full buffer, read bursts that run past empty, skips set
        // up to find their delimiter, skips left pending and then released,
        // and some plain noise.
        while (pending_words.size() < RANDOM_WORDS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                n = $urandom_range(4, 70);
                repeat (n) add_word(rrbs_pkg::OP_WRITE, pick_byte());
            end
            else if (kind <= 4)
            begin
                n = $urandom_range(2, 40);
                repeat (n) add_word(rrbs_pkg::OP_READ, pick_byte());
            end
            else if (kind <= 6)
            begin
                delim = pick_byte();
                n  = $urandom_range(1, 12);
                at = $urandom_range(0, n - 1);
                for (int i = 0; i < n; i++)
                    add_word(rrbs_pkg::OP_WRITE, (i == at) ? delim : pick_byte());
                repeat ($urandom_range(0, 2)) add_word(rrbs_pkg::OP_READ, pick_byte());
                add_word(rrbs_pkg::OP_SKIP, delim);
                if ($urandom_range(0, 1) == 1)
                    add_word(rrbs_pkg::OP_STATUS, pick_byte());
            end
            else if (kind == 7)
            begin
                delim = pick_byte();
                add_word(rrbs_pkg::OP_SKIP, delim);
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++)
                begin
                    b = pick_byte();
                    case ($urandom_range(0, 5))
                        0:       add_word(rrbs_pkg::OP_READ, b);
                        1:       add_word(rrbs_pkg::OP_STATUS, b);
                        2:       add_word(rrbs_pkg::OP_SKIP, b);
                        default: add_word(rrbs_pkg::OP_WRITE, b);
                    endcase
                end
                add_word(rrbs_pkg::OP_WRITE, delim);
                repeat ($urandom_range(0, 4)) add_word(rrbs_pkg::OP_WRITE, pick_byte());
            end
            else
            begin
                n = $urandom_range(5, 25);
                repeat (n) add_word(rrbs_pkg::op_t'($urandom_range(0, 3)), pick_byte());
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() > 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end

        $display("Sent %0d words: %0d writes, %0d reads, %0d skips, %0d status; %0d checked.",
                 words_in, n_write, n_read, n_skip, n_status, results_checked);
        $display("Saw %0d full drops, %0d pending-skip drops, %0d empty reads, %0d open skips.",
                 n_full_drop, n_skip_drop, n_empty_read, n_skip_left_armed);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/rrbs_pkg.sv
sv/rrbs_ram.sv
sv/rrbs_ctrl.sv
sv/rrbs_dp.sv
sv/rx_ring_buffer_with_skip_core.sv
sv/rrbs_checker.sv
verif/tb_rx_ring_buffer_with_skip_core.sv
